>>> rtl/tlw_pkg.sv
// Package with the character codes, register indexes and sequencer types of the line wrapper.
package tlw_pkg;

  localparam int HELD_DEPTH = 64;
  localparam int HAW = 6;
  localparam int HCW = 7;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [1:0] MODE_WORD  = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_SOLID = 2'd2;
  localparam logic [1:0] MODE_PASS  = 2'd3;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  localparam logic [1:0] MODE_RESET  = MODE_PASS;
  localparam logic [5:0] WIDTH_RESET = 6'd63;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE,
    PH_FLUSH,
    PH_POST,
    PH_MARK
  } phase_t;

endpackage

>>> rtl/text_line_wrapper_top.sv
// Streaming greedy word wrapper with a held-word memory and an output sequencer.
//
// Text enters one byte per word on the in channel (in_valid, in_stall) together
// with end_of_text, and reflowed bytes leave on the out channel (out_valid,
// out_stall), each tagged with no_byte, run_last and text_last. Mode and line
// width are written through cfg_en, cfg_index and cfg_data; the user must write
// them only while the block idles, as the block does not enforce it. The words
// that an input word causes are sent one per cycle from the output sequencer
// while out_stall does not hold them; in_stall stays high until the last of them
// has entered the fetch stage, and a held character with no output is not stalled.
// A held word is replayed from a 64-entry memory with a registered read that runs
// in step with the fetch stage, so a word read back from the memory reaches
// out_valid along the same path as a literal byte.
// The fetch stage and the output register form a two-deep pipeline, so a stall
// on the out side holds both and then backs up into in_stall.
// Reset sets pass mode and width 63 and empties the held count; the held
// memory is not cleared, since only entries below the held count are read.
module text_line_wrapper_top #(
  parameter int MAX_LINE = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_en,
  input  logic       cfg_index,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       no_byte,
  output logic       run_last,
  output logic       text_last
);

  localparam int LRW_MIN = $clog2(MAX_LINE + 2);
  localparam int LRW = (LRW_MIN > tlw_pkg::HCW) ? LRW_MIN : tlw_pkg::HCW;
  localparam logic [LRW-1:0] RUN_MAX = LRW'(MAX_LINE + 1);

  logic [1:0] mode;
  logic [5:0] line_width;
  logic [tlw_pkg::HCW-1:0] held_count;
  logic [LRW-1:0] line_run;
  logic break_pending;

  logic [7:0] held_text [tlw_pkg::HELD_DEPTH];
  logic [7:0] mem_q;

  tlw_pkg::phase_t phase, phase_next;
  logic [tlw_pkg::HAW-1:0] ptr;
  logic [tlw_pkg::HCW-1:0] f_end;
  logic [7:0] pre_b, post_b;
  logic post_v, flush_nz, eot_r;
  logic wr_pend;
  logic [tlw_pkg::HAW-1:0] wr_addr;
  logic [7:0] wr_data;

  logic st_valid, st_mem, st_nob, st_rl, st_tl;
  logic [7:0] st_lit;

  logic accept, issue, moved, is_last, rd_en;
  logic [7:0] issue_byte;

  logic [7:0] c;
  logic [LRW-1:0] lr_b;
  logic over, is_brk;
  logic p_pre_v, p_post_v, p_wr_v, p_flush_nz;
  logic [7:0] p_pre_b, p_post_b, p_wr_d;
  logic [tlw_pkg::HAW-1:0] p_first, p_wr_a;
  logic [tlw_pkg::HCW-1:0] p_end, hc_n, hc_inc;
  logic [LRW-1:0] lr_n;
  logic pend_n, p_any;

  logic mem_we;
  logic [tlw_pkg::HAW-1:0] mem_waddr;
  logic [7:0] mem_wdata;

  assign in_stall = (phase != tlw_pkg::PH_IDLE);
  assign accept   = in_valid && !in_stall;
  assign moved    = st_valid && (!out_valid || !out_stall);
  assign issue    = (phase != tlw_pkg::PH_IDLE) && (!st_valid || moved);
  assign rd_en    = issue && (phase == tlw_pkg::PH_FLUSH);

  always_comb begin
    c = text_byte;
    if (mode == tlw_pkg::MODE_FILL && c == tlw_pkg::CH_NL) begin
      c = tlw_pkg::CH_SP;
    end
    is_brk = (c == tlw_pkg::CH_SP) || (c == tlw_pkg::CH_DOT) ||
             (c == tlw_pkg::CH_COMMA) || (c == tlw_pkg::CH_SLASH);
    lr_b = (line_run < RUN_MAX) ? line_run + LRW'(1) : line_run;
    over = lr_b > LRW'(line_width);
    hc_inc = held_count + tlw_pkg::HCW'(1);

    p_pre_v = 1'b0;
    p_pre_b = c;
    p_first = '0;
    p_end = '0;
    p_post_v = 1'b0;
    p_post_b = c;
    p_wr_v = 1'b0;
    p_wr_a = '0;
    p_wr_d = c;
    hc_n = held_count;
    lr_n = line_run;
    pend_n = break_pending;

    if (mode == tlw_pkg::MODE_WORD || mode == tlw_pkg::MODE_FILL) begin
      if (c == tlw_pkg::CH_NL) begin
        p_end = held_count;
        p_post_v = 1'b1;
        p_post_b = tlw_pkg::CH_NL;
        hc_n = '0;
        pend_n = 1'b0;
        lr_n = '0;
      end else if (is_brk) begin
        p_end = held_count;
        if (over) begin
          p_post_v = 1'b1;
          p_post_b = tlw_pkg::CH_NL;
          lr_n = '0;
          hc_n = '0;
          pend_n = 1'b0;
        end else begin
          lr_n = lr_b;
          if (end_of_text) begin
            p_post_v = 1'b1;
          end else begin
            p_wr_v = 1'b1;
            p_wr_a = '0;
            hc_n = tlw_pkg::HCW'(1);
            pend_n = 1'b1;
          end
        end
      end else if (break_pending) begin
        if (over) begin
          p_pre_v = 1'b1;
          p_pre_b = tlw_pkg::CH_NL;
          p_first = tlw_pkg::HAW'(1);
          p_end = held_count;
          p_post_v = 1'b1;
          lr_n = LRW'(held_count);
          hc_n = '0;
          pend_n = 1'b0;
        end else if (hc_inc >= tlw_pkg::HCW'(tlw_pkg::HELD_DEPTH) || end_of_text) begin
          p_end = held_count;
          p_post_v = 1'b1;
          lr_n = lr_b;
          hc_n = '0;
          pend_n = 1'b0;
        end else begin
          p_wr_v = 1'b1;
          p_wr_a = held_count[tlw_pkg::HAW-1:0];
          hc_n = hc_inc;
          lr_n = lr_b;
        end
      end else begin
        p_post_v = 1'b1;
        lr_n = lr_b;
      end
    end else if (held_count != '0) begin
      p_end = held_count;
      p_post_v = 1'b1;
      lr_n = '0;
      hc_n = '0;
      pend_n = 1'b0;
    end else if (mode == tlw_pkg::MODE_SOLID) begin
      if (c != tlw_pkg::CH_NL) begin
        p_pre_v = 1'b1;
        if (lr_b >= LRW'(line_width)) begin
          p_post_v = 1'b1;
          p_post_b = tlw_pkg::CH_NL;
          lr_n = '0;
        end else begin
          lr_n = lr_b;
        end
      end
    end else begin
      p_post_v = 1'b1;
    end

    if (end_of_text) begin
      lr_n = '0;
      hc_n = '0;
      pend_n = 1'b0;
      p_wr_v = 1'b0;
    end

    p_flush_nz = p_end > tlw_pkg::HCW'(p_first);
    p_any = p_pre_v || p_flush_nz || p_post_v;
  end

  always_comb begin
    phase_next = phase;
    issue_byte = '0;
    unique case (phase)
      tlw_pkg::PH_IDLE: begin
        if (accept) begin
          if (p_pre_v) begin
            phase_next = tlw_pkg::PH_PRE;
          end else if (p_flush_nz) begin
            phase_next = tlw_pkg::PH_FLUSH;
          end else if (p_post_v) begin
            phase_next = tlw_pkg::PH_POST;
          end else if (end_of_text) begin
            phase_next = tlw_pkg::PH_MARK;
          end
        end
      end
      tlw_pkg::PH_PRE: begin
        issue_byte = pre_b;
        if (issue) begin
          if (flush_nz) begin
            phase_next = tlw_pkg::PH_FLUSH;
          end else if (post_v) begin
            phase_next = tlw_pkg::PH_POST;
          end else begin
            phase_next = tlw_pkg::PH_IDLE;
          end
        end
      end
      tlw_pkg::PH_FLUSH: begin
        if (issue && (tlw_pkg::HCW'(ptr) + tlw_pkg::HCW'(1)) == f_end) begin
          phase_next = post_v ? tlw_pkg::PH_POST : tlw_pkg::PH_IDLE;
        end
      end
      tlw_pkg::PH_POST: begin
        issue_byte = post_b;
        if (issue) begin
          phase_next = tlw_pkg::PH_IDLE;
        end
      end
      tlw_pkg::PH_MARK: begin
        if (issue) begin
          phase_next = tlw_pkg::PH_IDLE;
        end
      end
      default: phase_next = tlw_pkg::PH_IDLE;
    endcase
  end

  assign is_last = issue && (phase_next == tlw_pkg::PH_IDLE);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = p_wr_a;
    mem_wdata = p_wr_d;
    if (accept && p_wr_v && !p_any) begin
      mem_we = 1'b1;
    end else if (is_last && wr_pend) begin
      mem_we = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) held_text[mem_waddr] <= mem_wdata;
    if (rd_en) mem_q <= held_text[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tlw_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= tlw_pkg::MODE_RESET;
      line_width <= tlw_pkg::WIDTH_RESET;
      held_count <= '0;
      line_run <= '0;
      break_pending <= 1'b0;
      wr_pend <= 1'b0;
      st_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_en) begin
        unique case (cfg_index)
          tlw_pkg::REG_MODE:  mode <= cfg_data[1:0];
          tlw_pkg::REG_WIDTH: line_width <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        held_count <= hc_n;
        line_run <= lr_n;
        break_pending <= pend_n;
        wr_pend <= p_wr_v && p_any;
      end else if (is_last) begin
        wr_pend <= 1'b0;
      end
      if (issue) begin
        st_valid <= 1'b1;
      end else if (moved) begin
        st_valid <= 1'b0;
      end
      if (moved) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ptr <= p_first;
      f_end <= p_end;
      flush_nz <= p_flush_nz;
      pre_b <= p_pre_b;
      post_v <= p_post_v;
      post_b <= p_post_b;
      eot_r <= end_of_text;
      wr_addr <= p_wr_a;
      wr_data <= p_wr_d;
    end else if (rd_en) begin
      ptr <= ptr + tlw_pkg::HAW'(1);
    end
    if (issue) begin
      st_mem <= (phase == tlw_pkg::PH_FLUSH);
      st_lit <= issue_byte;
      st_nob <= (phase == tlw_pkg::PH_MARK);
      st_rl <= is_last;
      st_tl <= is_last && eot_r;
    end
    if (moved) begin
      out_byte <= st_mem ? mem_q : st_lit;
      no_byte <= st_nob;
      run_last <= st_rl;
      text_last <= st_tl;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count < tlw_pkg::HCW'(tlw_pkg::HELD_DEPTH))
    else $error("Held count exceeds the held memory depth.");

  a_pend_count: assert property (@(posedge clk) disable iff (rst)
    break_pending == (held_count != '0))
    else $error("Break flag disagrees with the held count.");

  a_flush_range: assert property (@(posedge clk) disable iff (rst)
    (phase == tlw_pkg::PH_FLUSH) |-> (tlw_pkg::HCW'(ptr) < f_end))
    else $error("Flush pointer ran past the held text.");

  a_text_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_last) |-> run_last)
    else $error("End of text flagged on a word that does not close its run.");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (wr_pend && phase == tlw_pkg::PH_IDLE) |-> !accept)
    else $error("Deferred held write still pending when a new word is taken.");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the text line wrapper, with a built-in prediction of every output word.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINE     = 63;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 410;

  typedef struct packed {
    logic [7:0] ch;
    logic       nob;
    logic       lastr;
    logic       lastt;
  } wrap_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_en = 1'b0;
  logic       cfg_index = tlw_pkg::REG_MODE;
  logic [5:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] text_byte = '0;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       no_byte;
  logic       run_last;
  logic       text_last;

  bit in_idle_on;
  bit out_idle_on;
  bit long_hold_req;
  int mismatches;

  logic [1:0] cur_mode;
  int         cur_width;
  logic [7:0] held_mem [tlw_pkg::HELD_DEPTH];
  int         held_n;
  int         run_len;
  bit         brk_held;
  wrap_out_t  step_out[$];
  wrap_out_t  expected_out[$];

  text_line_wrapper_top #(.MAX_LINE(MAX_LINE)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_en(cfg_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .text_byte(text_byte),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .no_byte(no_byte),
    .run_last(run_last),
    .text_last(text_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void emit_char(input logic [7:0] b);
    wrap_out_t w;
    if (step_out.size() < tlw_pkg::HELD_DEPTH) begin
      w = '{ch: b, nob: 1'b0, lastr: 1'b0, lastt: 1'b0};
      step_out.push_back(w);
    end
  endfunction

  function automatic void flush_held(input int first);
    for (int i = first; i < held_n && i < tlw_pkg::HELD_DEPTH; i++) begin
      emit_char(held_mem[i]);
    end
    held_n = 0;
    brk_held = 1'b0;
  endfunction

  function automatic void bump_run();
    if (run_len < MAX_LINE + 1) begin
      run_len++;
    end
  endfunction

  function automatic bit is_break(input logic [7:0] c);
    return c == tlw_pkg::CH_SP || c == tlw_pkg::CH_DOT ||
           c == tlw_pkg::CH_COMMA || c == tlw_pkg::CH_SLASH;
  endfunction

  function automatic void word_wrap_step(input logic [7:0] c_in);
    logic [7:0] c;
    int rest;
    c = c_in;
    if (cur_mode == tlw_pkg::MODE_FILL && c == tlw_pkg::CH_NL) begin
      c = tlw_pkg::CH_SP;
    end
    if (c == tlw_pkg::CH_NL) begin
      flush_held(0);
      emit_char(tlw_pkg::CH_NL);
      run_len = 0;
    end else if (is_break(c)) begin
      bump_run();
      flush_held(0);
      if (run_len > cur_width) begin
        emit_char(tlw_pkg::CH_NL);
        run_len = 0;
      end else begin
        held_mem[0] = c;
        held_n = 1;
        brk_held = 1'b1;
      end
    end else begin
      bump_run();
      if (brk_held) begin
        held_mem[held_n % tlw_pkg::HELD_DEPTH] = c;
        held_n++;
        if (run_len > cur_width) begin
          rest = held_n - 1;
          emit_char(tlw_pkg::CH_NL);
          flush_held(1);
          run_len = rest;
        end else if (held_n >= tlw_pkg::HELD_DEPTH) begin
          flush_held(0);
        end
      end else begin
        emit_char(c);
      end
    end
  endfunction

  function automatic void predict_wrap(input logic [7:0] c, input logic eot);
    int last;
    step_out.delete();
    if (cur_mode == tlw_pkg::MODE_WORD || cur_mode == tlw_pkg::MODE_FILL) begin
      word_wrap_step(c);
    end else if (held_n > 0) begin
      flush_held(0);
      emit_char(c);
      run_len = 0;
    end else if (cur_mode == tlw_pkg::MODE_SOLID) begin
      if (c != tlw_pkg::CH_NL) begin
        emit_char(c);
        bump_run();
        if (run_len >= cur_width) begin
          emit_char(tlw_pkg::CH_NL);
          run_len = 0;
        end
      end
    end else begin
      emit_char(c);
    end
    if (eot) begin
      flush_held(0);
      run_len = 0;
      if (step_out.size() == 0) begin
        emit_char(8'h00);
        step_out[0].nob = 1'b1;
      end
      last = step_out.size() - 1;
      step_out[last].lastt = 1'b1;
    end
    if (step_out.size() > 0) begin
      last = step_out.size() - 1;
      step_out[last].lastr = 1'b1;
    end
    foreach (step_out[i]) begin
      expected_out.push_back(step_out[i]);
    end
  endfunction

  always @(posedge clk) begin : check_output
    wrap_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_out.size() == 0) begin
        $display("%0t: output word with none expected: byte %h no_byte %b run_last %b text_last %b",
                 $time, out_byte, no_byte, run_last, text_last);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if ({out_byte, no_byte, run_last, text_last} !== want) begin
          $display("%0t: mismatch expected byte %h no_byte %b run_last %b text_last %b",
                   $time, want.ch, want.nob, want.lastr, want.lastt);
          $display("%0t:          actual   byte %h no_byte %b run_last %b text_last %b",
                   $time, out_byte, no_byte, run_last, text_last);
          mismatches++;
        end
      end
    end
  end

  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_wrap(b, eot);
  endtask

  task automatic send_string(input string s, input bit eot);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot && i == s.len() - 1);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers are written on back-to-back cycles while the block is idle.
  task automatic configure(input logic [1:0] mode, input int width);
    settle();
    cfg_en <= 1'b1;
    cfg_index <= tlw_pkg::REG_MODE;
    cfg_data <= {4'($urandom), mode};
    @(posedge clk);
    cfg_index <= tlw_pkg::REG_WIDTH;
    cfg_data <= 6'(width);
    @(posedge clk);
    cfg_en <= 1'b0;
    cur_mode = mode;
    cur_width = width;
  endtask

  task automatic test_pass_through();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(tlw_pkg::CH_NL, 1'b0);
    send_byte("A", 1'b1);
    settle();
  endtask

  task automatic test_word_breaks();
    configure(tlw_pkg::MODE_WORD, 4);
    send_string("ab cd.e/f,g\n", 1'b0);
    send_byte("h", 1'b1);
    settle();
  endtask

  task automatic test_fill_mode();
    configure(tlw_pkg::MODE_FILL, 3);
    send_string("a\nbc d", 1'b1);
    settle();
  endtask

  task automatic test_solid_mode();
    configure(tlw_pkg::MODE_SOLID, 3);
    send_string("ab\ncd\n", 1'b1);
    configure(tlw_pkg::MODE_SOLID, 10);
    send_string("abcde", 1'b0);
    settle();
    configure(tlw_pkg::MODE_SOLID, 2);
    send_byte("f", 1'b1);
    settle();
  endtask

  task automatic test_zero_width();
    configure(tlw_pkg::MODE_WORD, 0);
    send_string("a b", 1'b1);
    configure(tlw_pkg::MODE_SOLID, 0);
    send_string("xy", 1'b1);
    settle();
  endtask

  task automatic test_mode_switch();
    configure(tlw_pkg::MODE_WORD, 20);
    send_string("ab cd", 1'b0);
    settle();
    configure(tlw_pkg::MODE_PASS, 20);
    send_byte("e", 1'b1);
    configure(tlw_pkg::MODE_FILL, 20);
    send_string("x y", 1'b0);
    settle();
    configure(tlw_pkg::MODE_SOLID, 20);
    send_byte("z", 1'b1);
    settle();
  endtask

  function automatic logic [7:0] pick_text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(97, 122));
    else if (r < 68) return tlw_pkg::CH_SP;
    else if (r < 72) return tlw_pkg::CH_DOT;
    else if (r < 76) return tlw_pkg::CH_COMMA;
    else if (r < 80) return tlw_pkg::CH_SLASH;
    else if (r < 86) return tlw_pkg::CH_NL;
    else return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_random_text(input int total);
    int sent;
    int chunk;
    int burst;
    int r;
    int width;
    logic [1:0] mode;
    bit pressed;
    pressed = 1'b0;
    sent = 0;
    while (sent < total) begin
      r = $urandom_range(0, 99);
      mode = r < 40 ? tlw_pkg::MODE_WORD : r < 70 ? tlw_pkg::MODE_FILL :
             r < 85 ? tlw_pkg::MODE_SOLID : tlw_pkg::MODE_PASS;
      r = $urandom_range(0, 99);
      width = r < 10 ? 1 : r < 20 ? 63 : r < 24 ? 0 : $urandom_range(4, 30);
      chunk = $urandom_range(15, 45);
      if (!pressed && sent > total / 3) begin
        mode = tlw_pkg::MODE_WORD;
        width = 8;
        chunk = 60;
      end
      configure(mode, width);
      in_idle_on = sent < total * 3 / 4 && $urandom_range(0, 3) != 0;
      out_idle_on = sent < total * 3 / 4 && $urandom_range(0, 3) != 0;
      if (!pressed && sent > total / 3) begin
        pressed = 1'b1;
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < chunk; i++) begin
        if ($urandom_range(0, 24) == 0) begin
          burst = $urandom_range(20, 40);
          repeat (burst) send_byte(8'($urandom_range(97, 122)), 1'b0);
          sent += burst;
        end
        send_byte(pick_text_char(),
                  $urandom_range(0, 39) == 0 || (i == chunk - 1 && $urandom_range(0, 1) == 0));
      end
      sent += chunk;
      settle();
    end
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
  endtask

  initial begin
    cur_mode = tlw_pkg::MODE_RESET;
    cur_width = tlw_pkg::WIDTH_RESET;
    held_n = 0;
    run_len = 0;
    brk_held = 1'b0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_pass_through();
    test_word_breaks();
    test_fill_mode();
    test_solid_mode();
    test_zero_width();
    test_mode_switch();
    test_random_text(RANDOM_ITEMS);
    settle();
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tlw_pkg.sv
rtl/text_line_wrapper_top.sv
sim/testbench.sv
